// File: sv/pba_pkg.sv
// Shared types, constants and codes of the page bitmap allocator.
package pba_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W = 5;
  localparam int PIDX_W = 21;
  localparam int REG_W = 14;
  localparam int ADDR_W = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int DEFAULT_PAGE_COUNT = 8192;

  localparam logic [REG_W-1:0] FREE_START_RESET = 14'd512;
  localparam logic [REG_W-1:0] FREE_END_RESET = 14'd8192;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_ADDRESS = 2'd2;

  localparam logic CFG_FREE_START = 1'b0;
  localparam logic CFG_FREE_END = 1'b1;

  typedef enum logic [1:0] {
    OP_FIND,
    OP_SET,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_MOD
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } wu_res_t;

endpackage

// File: sv/pba_word_unit.sv
// Shared bitmap word unit: find-and-set first free bit, set range or clear range.
module pba_word_unit (
  input  logic [pba_pkg::WORD_W-1:0] word_in,
  input  pba_pkg::op_t               op,
  input  logic [pba_pkg::BIT_W-1:0]  lo_bit,
  input  logic [pba_pkg::BIT_W-1:0]  hi_bit,
  output logic [pba_pkg::WORD_W-1:0] word_out,
  output pba_pkg::wu_res_t           res
);

  logic [pba_pkg::WORD_W-1:0] mask;
  logic [pba_pkg::WORD_W-1:0] cand;
  logic [pba_pkg::WORD_W-1:0] pick;

  always_comb begin
    for (int k = 0; k < pba_pkg::WORD_W; k++) begin
      mask[k] = (pba_pkg::BIT_W'(k) >= lo_bit) && (pba_pkg::BIT_W'(k) <= hi_bit);
    end
    cand = ~word_in & mask;
    res.found = 1'b0;
    res.bit_idx = '0;
    for (int k = pba_pkg::WORD_W - 1; k >= 0; k--) begin
      if (cand[k]) begin
        res.found = 1'b1;
        res.bit_idx = pba_pkg::BIT_W'(k);
      end
    end
    pick = '0;
    pick[res.bit_idx] = res.found;
    unique case (op)
      pba_pkg::OP_FIND:  word_out = word_in | pick;
      pba_pkg::OP_SET:   word_out = word_in | mask;
      pba_pkg::OP_CLEAR: word_out = word_in & ~mask;
      default:           word_out = word_in;
    endcase
  end

endmodule

// File: sv/pba_seq.sv
// Sequencer and bitmap memory: request decode, word walk, clearing pass and result register.
module pba_seq #(
  parameter int PAGE_COUNT = pba_pkg::DEFAULT_PAGE_COUNT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_kind,
  input  logic [pba_pkg::ADDR_W-1:0]  in_address,
  input  logic [pba_pkg::ADDR_W-1:0]  in_end_address,
  input  logic [pba_pkg::REG_W-1:0]   free_start,
  input  logic [pba_pkg::REG_W-1:0]   free_end,
  output logic [pba_pkg::WORD_W-1:0]  wu_word,
  output pba_pkg::op_t                wu_op,
  output logic [pba_pkg::BIT_W-1:0]   wu_lo,
  output logic [pba_pkg::BIT_W-1:0]   wu_hi,
  input  logic [pba_pkg::WORD_W-1:0]  wu_word_new,
  input  pba_pkg::wu_res_t            wu_res,
  output logic                        out_valid,
  output logic [pba_pkg::ADDR_W-1:0]  out_page_address,
  output logic [1:0]                  out_status
);

  localparam int WORDS = (PAGE_COUNT + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [pba_pkg::PIDX_W-1:0] PC = pba_pkg::PIDX_W'(PAGE_COUNT);

  logic [pba_pkg::WORD_W-1:0] mem [WORDS];
  logic [pba_pkg::WORD_W-1:0] rdata_r;

  pba_pkg::state_t            state_r, state_nxt;
  pba_pkg::op_t               op_r, op_nxt;
  logic                       first_r, first_nxt;
  logic [AW-1:0]              cur_r, cur_nxt;
  logic [pba_pkg::BIT_W-1:0]  lo_bit_r, lo_bit_nxt;
  logic [AW-1:0]              last_word_r, last_word_nxt;
  logic [pba_pkg::BIT_W-1:0]  last_bit_r, last_bit_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [pba_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [pba_pkg::WORD_W-1:0] wdata;
  logic [AW-1:0]              raddr;

  logic [pba_pkg::PIDX_W-1:0] page_a, page_b, start_ext, end_ext, lim, e_clip;
  logic [pba_pkg::PIDX_W-1:0] req_lo, req_hi;
  pba_pkg::op_t               req_op;
  logic                       req_run;
  logic [1:0]                 req_status;
  logic                       is_last, done;

  assign busy = (state_r != pba_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_page_address = out_addr_r;
  assign out_status = out_status_r;

  assign wu_word = rdata_r;
  assign wu_op = op_r;
  assign wu_lo = first_r ? lo_bit_r : '0;
  assign wu_hi = (cur_r == last_word_r) ? last_bit_r : '1;

  always_comb begin
    page_a = pba_pkg::PIDX_W'(in_address[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT]);
    page_b = pba_pkg::PIDX_W'(in_end_address[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT]);
    start_ext = pba_pkg::PIDX_W'(free_start);
    end_ext = pba_pkg::PIDX_W'(free_end);
    lim = (end_ext > PC) ? PC : end_ext;
    e_clip = (page_b >= PC) ? PC - 1'b1 : page_b;
    req_lo = page_a;
    req_hi = page_a;
    req_op = pba_pkg::OP_FIND;
    req_run = 1'b0;
    req_status = pba_pkg::ST_OK;
    unique case (in_kind)
      pba_pkg::KIND_ALLOC: begin
        req_lo = start_ext;
        req_hi = lim - 1'b1;
        req_op = pba_pkg::OP_FIND;
        req_run = (start_ext < lim);
        req_status = pba_pkg::ST_NONE_FREE;
      end
      pba_pkg::KIND_FREE: begin
        req_op = pba_pkg::OP_CLEAR;
        if (page_a < start_ext || page_a > end_ext || page_a >= PC) begin
          req_status = pba_pkg::ST_BAD_ADDRESS;
        end else begin
          req_run = 1'b1;
        end
      end
      pba_pkg::KIND_RESERVE: begin
        req_hi = e_clip;
        req_op = pba_pkg::OP_SET;
        req_run = (page_a <= e_clip);
      end
      default: begin
        req_run = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    first_nxt = first_r;
    cur_nxt = cur_r;
    lo_bit_nxt = lo_bit_r;
    last_word_nxt = last_word_r;
    last_bit_nxt = last_bit_r;
    out_valid_nxt = 1'b0;
    out_addr_nxt = out_addr_r;
    out_status_nxt = out_status_r;
    we = 1'b0;
    waddr = cur_r;
    wdata = wu_word_new;
    raddr = cur_r;
    is_last = (cur_r == last_word_r);
    done = is_last || (op_r == pba_pkg::OP_FIND && wu_res.found);
    unique case (state_r)
      pba_pkg::S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        if (cur_r == LAST_WORD) begin
          state_nxt = pba_pkg::S_IDLE;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      pba_pkg::S_IDLE: begin
        if (start) begin
          if (req_run) begin
            op_nxt = req_op;
            first_nxt = 1'b1;
            cur_nxt = AW'(req_lo >> pba_pkg::BIT_W);
            lo_bit_nxt = req_lo[pba_pkg::BIT_W-1:0];
            last_word_nxt = AW'(req_hi >> pba_pkg::BIT_W);
            last_bit_nxt = req_hi[pba_pkg::BIT_W-1:0];
            state_nxt = pba_pkg::S_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
            out_addr_nxt = '0;
            out_status_nxt = req_status;
          end
        end
      end
      pba_pkg::S_FETCH: begin
        state_nxt = pba_pkg::S_MOD;
      end
      pba_pkg::S_MOD: begin
        we = 1'b1;
        if (done) begin
          state_nxt = pba_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          out_addr_nxt = '0;
          out_status_nxt = pba_pkg::ST_OK;
          if (op_r == pba_pkg::OP_FIND) begin
            if (wu_res.found) begin
              out_addr_nxt = pba_pkg::ADDR_W'({cur_r, wu_res.bit_idx}) << pba_pkg::PAGE_SHIFT;
            end else begin
              out_status_nxt = pba_pkg::ST_NONE_FREE;
            end
          end
        end else begin
          cur_nxt = cur_r + 1'b1;
          first_nxt = 1'b0;
          raddr = cur_r + 1'b1;
        end
      end
      default: begin
        state_nxt = pba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pba_pkg::S_CLEAR;
      cur_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    first_r <= first_nxt;
    lo_bit_r <= lo_bit_nxt;
    last_word_r <= last_word_nxt;
    last_bit_r <= last_bit_nxt;
    out_addr_r <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != pba_pkg::S_CLEAR |=> state_r != pba_pkg::S_CLEAR)
    else $error("clearing pass re-entered");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pba_pkg::S_MOD |-> cur_r <= last_word_r)
    else $error("word walk past last word");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == pba_pkg::S_MOD || (state_r == pba_pkg::S_IDLE && start)))
    else $error("result without transaction");

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != pba_pkg::ST_OK |-> out_addr_r == '0)
    else $error("nonzero address on failed transaction");

endmodule

// File: sv/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. in_kind selects alloc, free or reserve; in_address and
// in_end_address carry byte addresses whose low 12 bits are ignored.
// Each transaction yields one result: out_valid is high for exactly one
// cycle with out_page_address and out_status; the receiver cannot stall.
// Rejected frees, empty windows, empty reserve ranges and unused kinds
// answer in the cycle after acceptance. Other transactions walk the bitmap
// one 32-bit word per cycle through the shared word unit, after a fetch
// state that reads the first word into a register.
// busy stays high for the walk; the next transaction may start in the
// cycle that the result is shown.
// Configuration: cfg_we with cfg_index 0 (free start page) or 1 (free end
// page) writes cfg_wdata; write only while busy is low.
// Reset: synchronous, active low. It loads the window registers and then
// clears the bitmap, one word per cycle, with busy high.
module page_bitmap_allocator #(
  parameter int PAGE_COUNT = pba_pkg::DEFAULT_PAGE_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [pba_pkg::ADDR_W-1:0] in_address,
  input  logic [pba_pkg::ADDR_W-1:0] in_end_address,
  output logic                       out_valid,
  output logic [pba_pkg::ADDR_W-1:0] out_page_address,
  output logic [1:0]                 out_status,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pba_pkg::REG_W-1:0]  cfg_wdata
);

  logic [pba_pkg::REG_W-1:0]  free_start_r;
  logic [pba_pkg::REG_W-1:0]  free_end_r;
  logic [pba_pkg::WORD_W-1:0] wu_word;
  logic [pba_pkg::WORD_W-1:0] wu_word_new;
  pba_pkg::op_t               wu_op;
  logic [pba_pkg::BIT_W-1:0]  wu_lo;
  logic [pba_pkg::BIT_W-1:0]  wu_hi;
  pba_pkg::wu_res_t           wu_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_start_r <= pba_pkg::FREE_START_RESET;
      free_end_r <= pba_pkg::FREE_END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pba_pkg::CFG_FREE_START: free_start_r <= cfg_wdata;
        pba_pkg::CFG_FREE_END:   free_end_r <= cfg_wdata;
        default:                 free_end_r <= free_end_r;
      endcase
    end
  end

  pba_seq #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_end_address   (in_end_address),
    .free_start       (free_start_r),
    .free_end         (free_end_r),
    .wu_word          (wu_word),
    .wu_op            (wu_op),
    .wu_lo            (wu_lo),
    .wu_hi            (wu_hi),
    .wu_word_new      (wu_word_new),
    .wu_res           (wu_res),
    .out_valid        (out_valid),
    .out_page_address (out_page_address),
    .out_status       (out_status)
  );

  pba_word_unit u_word_unit (
    .word_in  (wu_word),
    .op       (wu_op),
    .lo_bit   (wu_lo),
    .hi_bit   (wu_hi),
    .word_out (wu_word_new),
    .res      (wu_res)
  );

endmodule

// File: bench/page_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit page bitmap allocator.
`timescale 1ns / 100ps

module page_bitmap_allocator_tb;

  localparam int CLK_PERIOD = 12;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PAGE_COUNT = pba_pkg::DEFAULT_PAGE_COUNT;
  localparam int N_DIRECTED = 32;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_CFG = 1'b1;

  typedef struct packed {
    logic [pba_pkg::ADDR_W-1:0] page_address;
    logic [1:0]                 status;
  } result_t;

  // cfg rows use cfg_reg and address[REG_W-1:0]; item rows use the rest
  typedef struct packed {
    logic                       row_kind;
    logic [1:0]                 kind;
    logic                       cfg_reg;
    logic [pba_pkg::ADDR_W-1:0] address;
    logic [pba_pkg::ADDR_W-1:0] end_address;
    logic                       typed;
    logic [pba_pkg::ADDR_W-1:0] exp_page_address;
    logic [1:0]                 exp_status;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_kind = '0;
  logic [pba_pkg::ADDR_W-1:0] in_address = '0;
  logic [pba_pkg::ADDR_W-1:0] in_end_address = '0;
  logic                       out_valid;
  logic [pba_pkg::ADDR_W-1:0] out_page_address;
  logic [1:0]                 out_status;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [pba_pkg::REG_W-1:0]  cfg_wdata = '0;

  logic    fixed_exp = 1'b0;
  result_t fixed_res = '0;

  bit                        frame_used [PAGE_COUNT];
  logic [pba_pkg::REG_W-1:0] win_start = pba_pkg::FREE_START_RESET;
  logic [pba_pkg::REG_W-1:0] win_end = pba_pkg::FREE_END_RESET;
  result_t                   pending_results [$];

  int err_cnt = 0;
  int n_cfg = 0;
  int kind_seen [4];
  int status_seen [4];

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00200000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00201000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h00200000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_BAD_ADDRESS},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b1, 32'h00000000, pba_pkg::ST_BAD_ADDRESS},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h01FFFFFF, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h02000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_BAD_ADDRESS},
    '{ROW_ITEM, pba_pkg::KIND_RESERVE, '0, 32'h00200000, 32'h00203FFF,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_RESERVE, '0, 32'h00300000, 32'h00200000,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_RESERVE, '0, 32'h01FFF000, 32'hFFFFFFFF,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_RESERVE, '0, 32'hFFFFF000, 32'hFFFFFFFF,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, KIND_UNUSED, '0, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_RESERVE, '0, 32'h00000000, 32'hFFFFFFFF,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_NONE_FREE},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h00200ABC, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_CFG, pba_pkg::KIND_ALLOC, pba_pkg::CFG_FREE_END, 32'd16383, '0,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_CFG, pba_pkg::KIND_ALLOC, pba_pkg::CFG_FREE_START, 32'd0, '0,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h01FFF123, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h01FFF000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_NONE_FREE},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h02000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_BAD_ADDRESS},
    '{ROW_CFG, pba_pkg::KIND_ALLOC, pba_pkg::CFG_FREE_START, 32'd16383, '0,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_NONE_FREE},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_BAD_ADDRESS},
    '{ROW_CFG, pba_pkg::KIND_ALLOC, pba_pkg::CFG_FREE_START, 32'd0, '0,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_CFG, pba_pkg::KIND_ALLOC, pba_pkg::CFG_FREE_END, 32'd0, '0,
      1'b0, '0, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h00000FFF, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_OK},
    '{ROW_ITEM, pba_pkg::KIND_ALLOC, '0, 32'h00000000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_NONE_FREE},
    '{ROW_ITEM, pba_pkg::KIND_FREE, '0, 32'h00001000, 32'h00000000,
      1'b1, 32'h00000000, pba_pkg::ST_BAD_ADDRESS}
  };

  page_bitmap_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_address       (in_address),
    .in_end_address   (in_end_address),
    .out_valid        (out_valid),
    .out_page_address (out_page_address),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("page_bitmap_allocator_tb: done, errors");
    $finish;
  end

  function automatic void predict_frame(input logic [1:0] kind,
                                        input logic [pba_pkg::ADDR_W-1:0] a,
                                        input logic [pba_pkg::ADDR_W-1:0] b,
                                        output result_t r);
    int  i;
    int  lim;
    int  s;
    int  e;
    bit  hit;
    r.page_address = '0;
    r.status = pba_pkg::ST_OK;
    s = int'(a[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT]);
    e = int'(b[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT]);
    case (kind)
      pba_pkg::KIND_ALLOC: begin
        lim = (win_end > PAGE_COUNT) ? PAGE_COUNT : win_end;
        hit = 1'b0;
        for (i = win_start; i < lim && !hit; i++) begin
          if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            r.page_address = pba_pkg::ADDR_W'(i) << pba_pkg::PAGE_SHIFT;
            hit = 1'b1;
          end
        end
        if (!hit) r.status = pba_pkg::ST_NONE_FREE;
      end
      pba_pkg::KIND_FREE: begin
        if (s < win_start || s > win_end || s >= PAGE_COUNT) r.status = pba_pkg::ST_BAD_ADDRESS;
        else frame_used[s] = 1'b0;
      end
      pba_pkg::KIND_RESERVE: begin
        if (e >= PAGE_COUNT) e = PAGE_COUNT - 1;
        for (i = s; i <= e && i < PAGE_COUNT; i++) frame_used[i] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: page_address %h status %0d", out_page_address, out_status);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_page_address !== want.page_address) begin
            $error("page_address: expected %h, got %h", want.page_address, out_page_address);
            err_cnt++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_cnt++;
          end
          status_seen[want.status]++;
        end
      end
      if (cfg_we === 1'b1) begin
        if (cfg_index == pba_pkg::CFG_FREE_START) win_start = cfg_wdata;
        else win_end = cfg_wdata;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predict_frame(in_kind, in_address, in_end_address, want);
        if (fixed_exp) want = fixed_res;
        pending_results.push_back(want);
        kind_seen[in_kind]++;
      end
    end
  end

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [pba_pkg::REG_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic send(input logic [1:0] kind, input logic [pba_pkg::ADDR_W-1:0] a,
                      input logic [pba_pkg::ADDR_W-1:0] b, input logic fixed,
                      input result_t fx);
    start <= 1'b1;
    in_kind <= kind;
    in_address <= a;
    in_end_address <= b;
    fixed_exp <= fixed;
    fixed_res <= fx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic hold_sender(input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int          ph;
    int          n;
    int          r;
    int          ws;
    int          we;
    int          lim;
    int          lo;
    int          hi;
    int          p;
    int          q;
    int          idle_pct;
    logic [1:0]  k;
    logic [31:0] a;
    logic [31:0] b;
    dir_row_t    row;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait_idle();

    for (n = 0; n < N_DIRECTED; n++) begin
      row = directed_rows[n];
      if (row.row_kind == ROW_CFG) begin
        write_reg(row.cfg_reg, row.address[pba_pkg::REG_W-1:0]);
      end else begin
        send(row.kind, row.address, row.end_address, row.typed,
             {row.exp_page_address, row.exp_status});
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = (ph < 3) ? 26 : ((ph < 6) ? 85 : 0);
      case (ph)
        0: begin ws = 512; we = 8192; end
        1: begin ws = 100; we = 140; end
        2: begin ws = 8160; we = 16383; end
        3: begin ws = $urandom_range(0, PAGE_COUNT - 1); we = ws + $urandom_range(1, 64); end
        4: begin ws = 0; we = 40; end
        5: begin ws = 6000; we = 5000; end
        6: begin ws = $urandom_range(0, 16383); we = $urandom_range(0, 16383); end
        default: begin ws = 8190; we = 8192; end
      endcase
      write_reg(pba_pkg::CFG_FREE_START, pba_pkg::REG_W'(ws));
      write_reg(pba_pkg::CFG_FREE_END, pba_pkg::REG_W'(we));
      lim = (we > PAGE_COUNT) ? PAGE_COUNT : we;

      // work on a small hot region; if the window is not empty, the region lies in it and is freed first
      if (ws < lim) begin
        lo = ws + $urandom_range(0, (lim - ws > 24) ? lim - ws - 24 : 0);
        hi = lo + $urandom_range(3, 23);
        if (hi > lim - 1) hi = lim - 1;
        for (p = lo; p <= hi; p++) begin
          hold_sender(idle_pct);
          a = $urandom;
          send(pba_pkg::KIND_FREE, {p[19:0], a[11:0]}, $urandom, 1'b0, '0);
        end
      end else begin
        lo = $urandom_range(0, PAGE_COUNT - 9);
        hi = lo + 8;
      end

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) wait_idle();
        hold_sender(idle_pct);
        r = $urandom_range(0, 99);
        a = $urandom;
        b = $urandom;
        p = $urandom_range(lo, hi);
        if (r < 35) begin
          k = pba_pkg::KIND_ALLOC;
        end else if (r < 60) begin
          k = pba_pkg::KIND_FREE;
          a = {p[19:0], a[11:0]};
        end else if (r < 68) begin
          k = pba_pkg::KIND_FREE;
          case ($urandom_range(0, 5))
            0: p = ws - 1;
            1: p = ws;
            2: p = we;
            3: p = we + 1;
            4: p = PAGE_COUNT - 1;
            default: p = PAGE_COUNT;
          endcase
          a = {p[19:0], a[11:0]};
        end else if (r < 78) begin
          k = pba_pkg::KIND_RESERVE;
          q = p + $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0) begin
            a = {q[19:0], a[11:0]};
            b = {p[19:0], b[11:0]};
          end else begin
            a = {p[19:0], a[11:0]};
            b = {q[19:0], b[11:0]};
          end
        end else if (r < 81) begin
          k = pba_pkg::KIND_RESERVE;
          a = {lo[19:0], a[11:0]};
          b = {hi[19:0], b[11:0]};
        end else if (r < 86) begin
          k = KIND_UNUSED;
        end else begin
          k = 2'($urandom_range(0, 3));
        end
        send(k, a, b, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_cnt++;
    end
    $display("covered %0d alloc, %0d free, %0d reserve, %0d unused-kind transactions",
             kind_seen[pba_pkg::KIND_ALLOC], kind_seen[pba_pkg::KIND_FREE],
             kind_seen[pba_pkg::KIND_RESERVE], kind_seen[KIND_UNUSED]);
    $display("%0d reg writes; results: %0d ok, %0d none_free, %0d bad_address",
             n_cfg, status_seen[pba_pkg::ST_OK], status_seen[pba_pkg::ST_NONE_FREE],
             status_seen[pba_pkg::ST_BAD_ADDRESS]);
    if (err_cnt == 0) begin
      $display("page_bitmap_allocator_tb: done, clean");
    end else begin
      $display("page_bitmap_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pba_pkg.sv
sv/pba_word_unit.sv
sv/pba_seq.sv
sv/page_bitmap_allocator.sv
bench/page_bitmap_allocator_tb.sv
